[rtl/atile_pkg.sv]
package atile_pkg;

  localparam int MAX_COLS_DEF      = 64;
  localparam int MAX_ROWS_DEF      = 64;
  localparam int TILESET_COUNT_DEF = 16;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 6;
  localparam int TS_W        = 4;
  localparam int POS_W       = 8;
  localparam int CLASS_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int ENTRY_W     = 12;
  localparam int DIM_W       = 8;
  localparam int STEP_W      = 4;
  localparam int NUM_CLASSES = 37;
  localparam int SQUARE_LEN  = 9;
  localparam int NBR_COUNT   = 8;
  localparam int ROOM_DIM_RESET = 64;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TILE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SQUARE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROOM_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM_HEIGHT = 2'd1;

  typedef struct packed {
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
  } geom_t;

  typedef struct packed {
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               in_range;
    logic [CLASS_W-1:0] tile_class;
    logic               last;
  } result_t;

endpackage

[rtl/atile_ram.sv]
module atile_ram import atile_pkg::*; #(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/atile_ctrl.sv]
module atile_ctrl import atile_pkg::*; #(
  parameter int MAX_COLS      = MAX_COLS_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF,
  parameter int TILESET_COUNT = TILESET_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  geom_t                                 geom,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [CMD_W-1:0]                      cmd,
  input  logic [COORD_W-1:0]                    col,
  input  logic [COORD_W-1:0]                    row,
  input  logic                                  tile_active,
  input  logic                                  tile_solid,
  input  logic [TS_W-1:0]                       tile_tileset,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output result_t                               res,
  output logic                                  mem_we,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]  mem_waddr,
  output logic [ENTRY_W-1:0]                    mem_wdata,
  output logic                                  mem_re,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]  mem_raddr,
  input  logic [ENTRY_W-1:0]                    mem_rdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SET   = 7'b0000100,
    S_TILE  = 7'b0001000,
    S_NBR   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  function automatic logic signed [POS_W-1:0] sq_dc(input logic [STEP_W-1:0] s);
    logic signed [POS_W-1:0] v;
    case (s)
      4'd0, 4'd3, 4'd6: v = POS_W'(-1);
      4'd1, 4'd4, 4'd7: v = '0;
      default:          v = POS_W'(1);
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sq_dr(input logic [STEP_W-1:0] s);
    logic signed [POS_W-1:0] v;
    case (s)
      4'd0, 4'd1, 4'd2: v = POS_W'(-1);
      4'd3, 4'd4, 4'd5: v = '0;
      default:          v = POS_W'(1);
    endcase
    return v;
  endfunction

  // Neighbor order: left, top, right, bottom, top-left, top-right,
  // bottom-left, bottom-right.
  function automatic logic signed [POS_W-1:0] nb_dc(input logic [2:0] k);
    logic signed [POS_W-1:0] v;
    case (k)
      3'd0, 3'd4, 3'd6: v = POS_W'(-1);
      3'd1, 3'd3:       v = '0;
      default:          v = POS_W'(1);
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] nb_dr(input logic [2:0] k);
    logic signed [POS_W-1:0] v;
    case (k)
      3'd1, 3'd4, 3'd5: v = POS_W'(-1);
      3'd0, 3'd2:       v = '0;
      default:          v = POS_W'(1);
    endcase
    return v;
  endfunction

  function automatic logic [CLASS_W-1:0] classify(input logic [NBR_COUNT-1:0] n);
    logic l, t, r, b, tl, tr, bl, br;
    logic [CLASS_W-1:0] c;
    l = n[0]; t = n[1]; r = n[2]; b = n[3];
    tl = n[4]; tr = n[5]; bl = n[6]; br = n[7];
    if (l) begin
      if (t) begin
        if (r) begin
          if (b) begin
            if (tl) begin
              if (tr) begin
                if (bl) c = br ? 6'd0 : 6'd1;
                else    c = br ? 6'd2 : 6'd0;
              end else begin
                c = (bl && br) ? 6'd3 : 6'd0;
              end
            end else if (tr) begin
              c = (bl && br) ? 6'd4 : 6'd0;
            end else begin
              c = 6'd5;
            end
          end else if (tl) begin
            c = tr ? 6'd6 : 6'd7;
          end else begin
            c = tr ? 6'd8 : 6'd9;
          end
        end else if (b) begin
          if (tl) c = bl ? 6'd10 : 6'd11;
          else    c = bl ? 6'd12 : 6'd13;
        end else begin
          c = tl ? 6'd14 : 6'd15;
        end
      end else if (r) begin
        if (b) begin
          if (bl) c = br ? 6'd16 : 6'd17;
          else    c = br ? 6'd18 : 6'd19;
        end else begin
          c = 6'd20;
        end
      end else if (b) begin
        c = bl ? 6'd21 : 6'd22;
      end else begin
        c = 6'd23;
      end
    end else if (t) begin
      if (r) begin
        if (b) begin
          if (tr) c = br ? 6'd24 : 6'd25;
          else    c = br ? 6'd26 : 6'd27;
        end else begin
          c = tr ? 6'd28 : 6'd29;
        end
      end else begin
        c = b ? 6'd30 : 6'd31;
      end
    end else if (r) begin
      c = b ? (br ? 6'd32 : 6'd33) : 6'd34;
    end else begin
      c = b ? 6'd35 : 6'd36;
    end
    return c;
  endfunction

  state_t                  state;
  logic [AW-1:0]           clr_addr;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [POS_W-1:0] base_c;
  logic signed [POS_W-1:0] base_r;
  logic                    act_q;
  logic                    sol_q;
  logic [TS_W-1:0]         ts_q;
  logic [STEP_W-1:0]       step;
  logic [STEP_W-1:0]       k;
  logic                    nb_out;
  logic [ENTRY_W-1:0]      center;
  logic [NBR_COUNT-1:0]    links;
  logic                    res_ok;
  logic [CLASS_W-1:0]      res_class;

  logic signed [POS_W-1:0] tile_c;
  logic signed [POS_W-1:0] tile_r;
  logic signed [POS_W-1:0] acc_c;
  logic signed [POS_W-1:0] acc_r;
  logic [2*POS_W-1:0]      lin;
  logic                    in_map;
  logic [AW-1:0]           acc_addr;
  logic                    lnk;
  logic [2:0]              prev_k;
  logic [CLASS_W-1:0]      cls;
  logic                    slot_free;

  assign tile_c = base_c + ((cmd_q == CMD_SQUARE) ? sq_dc(step) : '0);
  assign tile_r = base_r + ((cmd_q == CMD_SQUARE) ? sq_dr(step) : '0);
  assign acc_c  = (state == S_NBR) ? tile_c + nb_dc(k[2:0]) : tile_c;
  assign acc_r  = (state == S_NBR) ? tile_r + nb_dr(k[2:0]) : tile_r;

  assign in_map = !acc_c[POS_W-1] && !acc_r[POS_W-1] &&
                  ($unsigned(acc_c) < geom.eff_w) && ($unsigned(acc_r) < geom.eff_h);
  assign lin = (2*POS_W)'($unsigned(acc_r)) * (2*POS_W)'(geom.eff_w) +
               (2*POS_W)'($unsigned(acc_c));
  assign acc_addr = lin[AW-1:0];

  assign lnk = nb_out || (mem_rdata[0] && mem_rdata[1] && mem_rdata[5:2] == center[5:2]);
  assign prev_k = 3'(k - STEP_W'(1));
  assign cls = classify(links);
  assign slot_free = !out_valid || !out_stall;

  assign in_stall  = (state != S_IDLE);
  assign mem_raddr = acc_addr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_SET: begin
        mem_we    = in_map;
        mem_wdata = {CLASS_W'(0), ts_q, sol_q, act_q};
      end
      S_TILE: begin
        mem_re = in_map;
      end
      S_NBR: begin
        mem_re = in_map && (k != STEP_W'(NBR_COUNT));
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_wdata = {cls, center[5:0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            base_c <= POS_W'(col);
            base_r <= POS_W'(row);
            act_q  <= tile_active;
            sol_q  <= tile_solid;
            ts_q   <= (int'(tile_tileset) >= TILESET_COUNT) ?
                      TS_W'(TILESET_COUNT - 1) : tile_tileset;
            step   <= '0;
            case (cmd)
              CMD_SET:    state <= S_SET;
              CMD_TILE:   state <= S_TILE;
              CMD_SQUARE: state <= S_TILE;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_SET: begin
          res_ok    <= in_map;
          res_class <= '0;
          state     <= S_EMIT;
        end
        S_TILE: begin
          res_ok    <= in_map;
          res_class <= '0;
          k         <= '0;
          state     <= in_map ? S_NBR : S_EMIT;
        end
        S_NBR: begin
          nb_out <= !in_map;
          if (k == '0) begin
            center <= mem_rdata;
          end else begin
            links[prev_k] <= lnk;
          end
          if (k == STEP_W'(NBR_COUNT)) begin
            state <= S_WB;
          end else begin
            k <= k + STEP_W'(1);
          end
        end
        S_WB: begin
          res_class <= cls;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            res.col        <= tile_c;
            res.row        <= tile_r;
            res.in_range   <= res_ok;
            res.tile_class <= res_class;
            res.last       <= (cmd_q != CMD_SQUARE) || (step == STEP_W'(SQUARE_LEN - 1));
            if ((cmd_q == CMD_SQUARE) && (step != STEP_W'(SQUARE_LEN - 1))) begin
              step  <= step + STEP_W'(1);
              state <= S_TILE;
            end else begin
              step  <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tile_map_neighbor_autotiler_core.sv]
// Tile map autotiler with eight-neighbor shape classes. The map lives in one
// single-port-read, single-port-write RAM of MAX_COLS*MAX_ROWS entries, and
// that one read port sets the pace. After reset the block clears the whole
// map, one entry per cycle, and holds in_stall high until the clearing pass
// is done. A set command passes through the set and emit states to its
// result word. An autotile of one tile reads the center and its eight
// neighbors one per cycle and writes the class back; an out-of-range tile
// skips the reads and write-back, and a 3x3 square handles its nine tiles in
// turn. One command is handled at a time; the result word waits in an
// output register, and the next command is accepted as soon as the last
// word of the current one has been loaded there.
module tile_map_neighbor_autotiler_core import atile_pkg::*; #(
  parameter int MAX_COLS      = MAX_COLS_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF,
  parameter int TILESET_COUNT = TILESET_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [COORD_W-1:0]      col,
  input  logic [COORD_W-1:0]      row,
  input  logic                    tile_active,
  input  logic                    tile_solid,
  input  logic [TS_W-1:0]         tile_tileset,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_col,
  output logic signed [POS_W-1:0] out_row,
  output logic                    in_range,
  output logic [CLASS_W-1:0]      tile_class,
  output logic                    last
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_DATA_W-1:0] room_width;
  logic [CFG_DATA_W-1:0] room_height;
  geom_t                 geom;
  result_t               res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ENTRY_W-1:0]    mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_width  <= CFG_DATA_W'(ROOM_DIM_RESET);
      room_height <= CFG_DATA_W'(ROOM_DIM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROOM_WIDTH) begin
        room_width <= cfg_data;
      end else if (cfg_index == REG_ROOM_HEIGHT) begin
        room_height <= cfg_data;
      end
    end
  end

  assign geom.eff_w = (int'(room_width) > MAX_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(room_width);
  assign geom.eff_h = (int'(room_height) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(room_height);

  atile_ctrl #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .TILESET_COUNT (TILESET_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .col          (col),
    .row          (row),
    .tile_active  (tile_active),
    .tile_solid   (tile_solid),
    .tile_tileset (tile_tileset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  atile_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_col    = $signed(res.col);
  assign out_row    = $signed(res.row);
  assign in_range   = res.in_range;
  assign tile_class = res.tile_class;
  assign last       = res.last;

`ifndef SYNTH
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd != CMD_NONE |=> in_stall)
    else $error("block took a command but did not become busy");

  a_class_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> tile_class == '0)
    else $error("out-of-map word carries a nonzero class");

  a_class_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tile_class <= CLASS_W'(NUM_CLASSES - 1))
    else $error("class beyond the last shape class");
`endif

endmodule

[tb/tb_tile_map_neighbor_autotiler_core.sv]
`timescale 1ns / 1ps

module tb_tile_map_neighbor_autotiler_core;
  import atile_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int MAP_DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT = 20000;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd;
  logic [COORD_W-1:0]      col;
  logic [COORD_W-1:0]      row;
  logic                    tile_active;
  logic                    tile_solid;
  logic [TS_W-1:0]         tile_tileset;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] res_col;
  logic signed [POS_W-1:0] res_row;
  logic                    res_in_range;
  logic [CLASS_W-1:0]      res_class;
  logic                    res_last;

  logic [ENTRY_W-1:0]    tiles [0:MAP_DEPTH-1];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  result_t               expected_words[$];
  result_t               want;
  int                    mismatches = 0;
  int                    idle_cycles = 0;
  int                    stall_left = 0;
  bit                    quiet = 1'b0;

  tile_map_neighbor_autotiler_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .col(col),
    .row(row),
    .tile_active(tile_active),
    .tile_solid(tile_solid),
    .tile_tileset(tile_tileset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_col(res_col),
    .out_row(res_row),
    .in_range(res_in_range),
    .tile_class(res_class),
    .last(res_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int used_cols();
    return (width_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(width_reg);
  endfunction

  function automatic int used_rows();
    return (height_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(height_reg);
  endfunction

  function automatic bit on_map(int c, int r);
    return c >= 0 && r >= 0 && c < used_cols() && r < used_rows();
  endfunction

  function automatic bit joins(int c, int r, logic [TS_W-1:0] ts);
    logic [ENTRY_W-1:0] e;
    if (!on_map(c, r)) return 1'b1;
    e = tiles[c + r * used_cols()];
    return e[0] && e[1] && (e[5:2] == ts);
  endfunction

  function automatic void queue_word(result_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic logic [CLASS_W-1:0] shape_of(bit w, bit n, bit e, bit s,
                                                   bit nw, bit ne, bit sw, bit se);
    if (w) begin
      if (n) begin
        if (e) begin
          if (s) begin
            if (nw) begin
              if (ne) begin
                if (sw) return se ? 6'd0 : 6'd1;
                return se ? 6'd2 : 6'd0;
              end
              return (sw && se) ? 6'd3 : 6'd0;
            end
            if (ne) return (sw && se) ? 6'd4 : 6'd0;
            return 6'd5;
          end
          if (nw) return ne ? 6'd6 : 6'd7;
          return ne ? 6'd8 : 6'd9;
        end
        if (s) begin
          if (nw) return sw ? 6'd10 : 6'd11;
          return sw ? 6'd12 : 6'd13;
        end
        return nw ? 6'd14 : 6'd15;
      end
      if (e) begin
        if (s) begin
          if (sw) return se ? 6'd16 : 6'd17;
          return se ? 6'd18 : 6'd19;
        end
        return 6'd20;
      end
      if (s) return sw ? 6'd21 : 6'd22;
      return 6'd23;
    end
    if (n) begin
      if (e) begin
        if (s) begin
          if (ne) return se ? 6'd24 : 6'd25;
          return se ? 6'd26 : 6'd27;
        end
        return ne ? 6'd28 : 6'd29;
      end
      return s ? 6'd30 : 6'd31;
    end
    if (e) begin
      if (s) return se ? 6'd32 : 6'd33;
      return 6'd34;
    end
    return s ? 6'd35 : 6'd36;
  endfunction

  function automatic void classify_tile(int c, int r, bit fin);
    result_t            w;
    logic [ENTRY_W-1:0] e;
    logic [TS_W-1:0]    ts;
    logic [CLASS_W-1:0] cls;
    w.col = c[POS_W-1:0];
    w.row = r[POS_W-1:0];
    w.last = fin;
    w.in_range = 1'b0;
    w.tile_class = '0;
    if (on_map(c, r)) begin
      e = tiles[c + r * used_cols()];
      ts = e[5:2];
      cls = shape_of(joins(c - 1, r, ts), joins(c, r - 1, ts),
                     joins(c + 1, r, ts), joins(c, r + 1, ts),
                     joins(c - 1, r - 1, ts), joins(c + 1, r - 1, ts),
                     joins(c - 1, r + 1, ts), joins(c + 1, r + 1, ts));
      tiles[c + r * used_cols()] = {cls, e[5:0]};
      w.in_range = 1'b1;
      w.tile_class = cls;
    end
    queue_word(w);
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] op, int c, int r,
                                        logic act, logic sol, logic [TS_W-1:0] ts);
    result_t         w;
    logic [TS_W-1:0] kept_ts;
    int              k;
    case (op)
      CMD_SET: begin
        kept_ts = ts;
        if (int'(ts) >= TILESET_COUNT_DEF) kept_ts = TS_W'(TILESET_COUNT_DEF - 1);
        w.col = c[POS_W-1:0];
        w.row = r[POS_W-1:0];
        w.in_range = on_map(c, r);
        w.tile_class = '0;
        w.last = 1'b1;
        if (w.in_range) tiles[c + r * used_cols()] = {6'd0, kept_ts, sol, act};
        queue_word(w);
      end
      CMD_TILE: begin
        classify_tile(c, r, 1'b1);
      end
      CMD_SQUARE: begin
        for (k = 0; k < SQUARE_LEN; k++) begin
          classify_tile(c + k % 3 - 1, r + k / 3 - 1, k == SQUARE_LEN - 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic note_mismatch(string what, int got_v, int want_v);
    if (mismatches < 100) begin
      $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, want_v, $realtime);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word col", int'(res_col), 0);
      end else begin
        want = expected_words.pop_front();
        if (res_col !== $signed(want.col))
          note_mismatch("out_col", int'(res_col), int'($signed(want.col)));
        if (res_row !== $signed(want.row))
          note_mismatch("out_row", int'(res_row), int'($signed(want.row)));
        if (res_in_range !== want.in_range)
          note_mismatch("in_range", int'(res_in_range), int'(want.in_range));
        if (res_class !== want.tile_class)
          note_mismatch("tile_class", int'(res_class), int'(want.tile_class));
        if (res_last !== want.last)
          note_mismatch("last", int'(res_last), int'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (quiet || stall_left == 0) begin
      out_stall <= 1'b0;
      if (!quiet) stall_left = pick_gap();
    end else begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [CMD_W-1:0] op, logic [COORD_W-1:0] c,
                           logic [COORD_W-1:0] r, logic act, logic sol,
                           logic [TS_W-1:0] ts);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= op;
    col <= c;
    row <= r;
    tile_active <= act;
    tile_solid <= sol;
    tile_tileset <= ts;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_command(op, int'(c), int'(r), act, sol, ts);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROOM_WIDTH) width_reg = data;
    else if (idx == REG_ROOM_HEIGHT) height_reg = data;
  endtask

  task automatic program_room(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              bit spares);
    wait_for_drain();
    cfg_word(REG_ROOM_WIDTH, w);
    cfg_word(REG_ROOM_HEIGHT, h);
    if (spares) begin
      cfg_word(REG_SPARE_2, CFG_DATA_W'($urandom));
      cfg_word(REG_SPARE_3, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_corner_tiles();
    send_word(CMD_SET, 6'd0, 6'd0, 1'b1, 1'b1, 4'd15);
    send_word(CMD_SET, 6'd63, 6'd63, 1'b1, 1'b1, 4'd15);
    send_word(CMD_SET, 6'd63, 6'd0, 1'b0, 1'b1, 4'd0);
    send_word(CMD_SET, 6'd0, 6'd63, 1'b1, 1'b0, 4'd5);
    send_word(CMD_TILE, 6'd0, 6'd0, 1'b0, 1'b0, 4'd0);
    send_word(CMD_TILE, 6'd63, 6'd0, 1'b1, 1'b1, 4'd15);
    send_word(CMD_SQUARE, 6'd63, 6'd63, 1'b0, 1'b0, 4'd0);
    send_word(CMD_SQUARE, 6'd0, 6'd0, 1'b1, 1'b1, 4'd15);
    send_word(CMD_NONE, 6'd5, 6'd5, 1'b1, 1'b1, 4'd15);
  endtask

  task automatic test_neighbor_shapes();
    int dc;
    int dr;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        send_word(CMD_SET, 6'(20 + dc), 6'(20 + dr), 1'b1, 1'b1,
                  (dc != 0 && dr != 0) ? 4'd9 : 4'd3);
      end
    end
    send_word(CMD_SQUARE, 6'd20, 6'd20, 1'b0, 1'b0, 4'd0);
    send_word(CMD_SET, 6'd21, 6'd20, 1'b1, 1'b0, 4'd3);
    send_word(CMD_TILE, 6'd20, 6'd20, 1'b0, 1'b0, 4'd0);
    send_word(CMD_SQUARE, 6'd21, 6'd21, 1'b0, 1'b0, 4'd0);
  endtask

  task automatic test_room_limits();
    program_room(7'd0, 7'd0, 1'b0);
    send_word(CMD_SET, 6'd0, 6'd0, 1'b1, 1'b1, 4'd2);
    send_word(CMD_TILE, 6'd0, 6'd0, 1'b0, 1'b0, 4'd0);
    program_room(7'd127, 7'd127, 1'b0);
    send_word(CMD_SET, 6'd63, 6'd63, 1'b1, 1'b1, 4'd7);
    send_word(CMD_SQUARE, 6'd63, 6'd63, 1'b0, 1'b0, 4'd0);
    program_room(7'd1, 7'd1, 1'b1);
    send_word(CMD_SQUARE, 6'd0, 6'd0, 1'b0, 1'b0, 4'd0);
    send_word(CMD_TILE, 6'd1, 6'd0, 1'b0, 1'b0, 4'd0);
  endtask

  task automatic run_room_phase(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                int count, bit calm);
    int              n;
    int              ox;
    int              oy;
    int              dice;
    logic [TS_W-1:0] ts_a;
    logic [TS_W-1:0] ts_b;
    logic [TS_W-1:0] ts;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    logic [CMD_W-1:0] op;
    logic act;
    logic sol;
    program_room(w, h, 1'b1);
    quiet = calm;
    ox = 0;
    oy = 0;
    ts_a = '0;
    ts_b = '0;
    for (n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        ox = (used_cols() > 0) ? $urandom_range(0, used_cols() - 1) : 0;
        oy = (used_rows() > 0) ? $urandom_range(0, used_rows() - 1) : 0;
        ts_a = TS_W'($urandom);
        ts_b = TS_W'($urandom);
      end
      c = COORD_W'(ox + $urandom_range(0, 5));
      r = COORD_W'(oy + $urandom_range(0, 5));
      if ($urandom_range(0, 9) == 0) ts = TS_W'($urandom);
      else ts = $urandom_range(0, 1) ? ts_a : ts_b;
      act = ($urandom_range(0, 6) != 0);
      sol = ($urandom_range(0, 6) != 0);
      dice = $urandom_range(0, 99);
      if (dice < 45) op = CMD_SET;
      else if (dice < 75) op = CMD_TILE;
      else if (dice < 92) op = CMD_SQUARE;
      else begin
        op = CMD_W'($urandom);
        c = COORD_W'($urandom);
        r = COORD_W'($urandom);
      end
      send_word(op, c, r, act, sol, ts);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_rooms();
    run_room_phase(7'd64, 7'd64, 90, 1'b0);
    run_room_phase(7'd7, 7'd5, 70, 1'b1);
    run_room_phase(7'd127, 7'd100, 80, 1'b0);
    run_room_phase(7'd1, 7'd64, 50, 1'b0);
    run_room_phase(7'd64, 7'd1, 50, 1'b1);
    run_room_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 70, 1'b0);
    run_room_phase(CFG_DATA_W'($urandom_range(8, 40)), CFG_DATA_W'($urandom_range(8, 40)),
                   70, 1'b0);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROOM_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd <= CMD_NONE;
    col <= '0;
    row <= '0;
    tile_active <= 1'b0;
    tile_solid <= 1'b0;
    tile_tileset <= '0;
    out_stall <= 1'b0;
    width_reg = CFG_DATA_W'(ROOM_DIM_RESET);
    height_reg = CFG_DATA_W'(ROOM_DIM_RESET);
    for (int i = 0; i < MAP_DEPTH; i++) tiles[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_corner_tiles();
    test_neighbor_shapes();
    test_room_limits();
    test_random_rooms();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[tile_map_neighbor_autotiler_core.f]
rtl/atile_pkg.sv
rtl/atile_ram.sv
rtl/atile_ctrl.sv
rtl/tile_map_neighbor_autotiler_core.sv
tb/tb_tile_map_neighbor_autotiler_core.sv
